/* rtl/mersenne_lucas_lehmer_test_macros.svh */
// ----------------------------------------------------------------------------
// mersenne_lucas_lehmer_test_macros
// assertion macros used by the lucas-lehmer test sequencer rtl
// ----------------------------------------------------------------------------
`ifndef MERSENNE_LUCAS_LEHMER_TEST_MACROS_SVH
`define MERSENNE_LUCAS_LEHMER_TEST_MACROS_SVH
`ifndef SYNTH
`define LLT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define LLT_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define LLT_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define LLT_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* rtl/mllt_pkg.sv */
// ----------------------------------------------------------------------------
// mllt_pkg
// shared constants and types for the lucas-lehmer test block
// ----------------------------------------------------------------------------
package mllt_pkg;

    localparam int MAX_LIMBS = 16;
    localparam int LIMB_W    = 64;
    localparam int HALF_W    = LIMB_W / 2;
    localparam int PROD_W    = 2 * LIMB_W;
    localparam int ACC_W     = PROD_W + 8;
    localparam int LIMB_AW   = $clog2(MAX_LIMBS);
    localparam int SQ_DEPTH  = 2 * MAX_LIMBS;
    localparam int SQ_AW     = $clog2(SQ_DEPTH);
    localparam int CNT_W     = LIMB_AW + 1;
    localparam int EXP_W     = 11;
    localparam int SH_W      = $clog2(LIMB_W);
    localparam int DRAIN_CYC = 4;

    localparam logic [EXP_W-1:0]  EXP_MAX   = EXP_W'(LIMB_W * MAX_LIMBS);
    localparam logic [EXP_W-1:0]  EXP_TWO   = EXP_W'(2);
    localparam logic [EXP_W:0]    EXP_RND   = (EXP_W+1)'(LIMB_W - 1);
    localparam logic [LIMB_W-1:0] SEED      = LIMB_W'(4);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_MUL,
        ST_DRAIN,
        ST_FOLD_PRE,
        ST_FOLD,
        ST_SUB,
        ST_FIX,
        ST_CHECK,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_INIT,
        OP_MUL,
        OP_FOLD_PRE,
        OP_FOLD,
        OP_SUB,
        OP_FIX,
        OP_CHECK
    } t_dp_op;

    typedef struct packed {
        t_dp_op               op;
        logic [LIMB_AW-1:0]   idx_a;
        logic [LIMB_AW-1:0]   idx_b;
        logic [SQ_AW:0]       sq_idx;
        logic [SQ_AW-1:0]     col;
        logic                 first;
        logic                 last;
        logic                 clear;
        logic                 zero;
        logic [CNT_W-1:0]     n;
        logic [SH_W-1:0]      rsh;
    } t_dp_cmd;

    typedef struct packed {
        logic is_zero;
    } t_dp_stat;

endpackage

/* rtl/mllt_ctrl.sv */
// ----------------------------------------------------------------------------
// mllt_ctrl
// sequencer: column-wise squaring, fold, minus two and final zero check
// ----------------------------------------------------------------------------
`include "mersenne_lucas_lehmer_test_macros.svh"

module mllt_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [mllt_pkg::EXP_W-1:0]   i_exponent,
    input  mllt_pkg::t_dp_stat           i_stat,
    output mllt_pkg::t_dp_cmd            o_cmd,
    output logic                         o_done,
    output logic                         o_prime,
    output logic                         o_too_large
);

    mllt_pkg::t_state                   r_state, n_state;
    logic [mllt_pkg::CNT_W-1:0]         r_n, n_n;
    logic [mllt_pkg::CNT_W-1:0]         r_w, n_w;
    logic [mllt_pkg::SH_W-1:0]          r_rsh, n_rsh;
    logic [mllt_pkg::EXP_W-1:0]         r_left, n_left;
    logic [mllt_pkg::CNT_W-1:0]         r_cnt, n_cnt;
    logic [mllt_pkg::SQ_AW-1:0]         r_col, n_col;
    logic [mllt_pkg::CNT_W-1:0]         r_i, n_i;
    logic                               r_special, n_special;
    logic                               r_spec_prime, n_spec_prime;
    logic                               r_too_large, n_too_large;

    logic [mllt_pkg::SQ_AW:0]           col_x, col1_x, n_x, two_n;
    logic [mllt_pkg::CNT_W-1:0]         i_lo, i_hi, i_lo_nx;
    logic [mllt_pkg::SQ_AW:0]           j_full;
    logic                               dummy, mul_last, pass_end;
    logic [mllt_pkg::EXP_W:0]           exp_up;

    always_comb begin
        col_x    = {1'b0, r_col};
        col1_x   = col_x + (mllt_pkg::SQ_AW+1)'(1);
        n_x      = (mllt_pkg::SQ_AW+1)'(r_n);
        two_n    = {r_n, 1'b0};
        i_lo     = (col_x < n_x) ? '0 :
                   mllt_pkg::CNT_W'(col1_x - n_x);
        i_hi     = (col_x < n_x) ? mllt_pkg::CNT_W'(r_col) :
                   r_n - mllt_pkg::CNT_W'(1);
        i_lo_nx  = (col1_x < n_x) ? '0 :
                   mllt_pkg::CNT_W'(col1_x + (mllt_pkg::SQ_AW+1)'(1) - n_x);
        j_full   = col_x - (mllt_pkg::SQ_AW+1)'(r_i);
        dummy    = (col1_x == two_n);
        mul_last = dummy || (r_i == i_hi);
        pass_end = (r_cnt == r_n);
        exp_up   = {1'b0, i_exponent} + mllt_pkg::EXP_RND;
    end

    // next state
    always_comb begin
        n_state      = r_state;
        n_n          = r_n;
        n_w          = r_w;
        n_rsh        = r_rsh;
        n_left       = r_left;
        n_cnt        = r_cnt;
        n_col        = r_col;
        n_i          = r_i;
        n_special    = r_special;
        n_spec_prime = r_spec_prime;
        n_too_large  = r_too_large;
        case (r_state)
            mllt_pkg::ST_IDLE: begin
                if (start) begin
                    n_too_large  = 1'b0;
                    n_special    = 1'b1;
                    n_spec_prime = 1'b0;
                    if (i_exponent > mllt_pkg::EXP_MAX) begin
                        n_too_large = 1'b1;
                        n_state     = mllt_pkg::ST_DONE;
                    end else if (i_exponent < mllt_pkg::EXP_TWO) begin
                        n_state = mllt_pkg::ST_DONE;
                    end else if (i_exponent == mllt_pkg::EXP_TWO) begin
                        n_spec_prime = 1'b1;
                        n_state      = mllt_pkg::ST_DONE;
                    end else begin
                        n_special = 1'b0;
                        n_n       = mllt_pkg::CNT_W'(exp_up >> mllt_pkg::SH_W);
                        n_w       = mllt_pkg::CNT_W'(i_exponent >> mllt_pkg::SH_W);
                        n_rsh     = i_exponent[mllt_pkg::SH_W-1:0];
                        n_left    = i_exponent - mllt_pkg::EXP_TWO;
                        n_cnt     = '0;
                        n_state   = mllt_pkg::ST_INIT;
                    end
                end
            end
            mllt_pkg::ST_INIT: begin
                if (pass_end) begin
                    n_cnt   = '0;
                    n_col   = '0;
                    n_i     = '0;
                    n_state = mllt_pkg::ST_MUL;
                end else begin
                    n_cnt = r_cnt + mllt_pkg::CNT_W'(1);
                end
            end
            mllt_pkg::ST_MUL: begin
                if (dummy) begin
                    n_cnt   = '0;
                    n_state = mllt_pkg::ST_DRAIN;
                end else if (mul_last) begin
                    n_col = r_col + mllt_pkg::SQ_AW'(1);
                    n_i   = i_lo_nx;
                end else begin
                    n_i = r_i + mllt_pkg::CNT_W'(1);
                end
            end
            mllt_pkg::ST_DRAIN: begin
                if (r_cnt == mllt_pkg::CNT_W'(mllt_pkg::DRAIN_CYC - 1)) begin
                    n_state = mllt_pkg::ST_FOLD_PRE;
                end else begin
                    n_cnt = r_cnt + mllt_pkg::CNT_W'(1);
                end
            end
            mllt_pkg::ST_FOLD_PRE: begin
                n_cnt   = '0;
                n_state = mllt_pkg::ST_FOLD;
            end
            mllt_pkg::ST_FOLD: begin
                if (pass_end) begin
                    n_cnt   = '0;
                    n_state = mllt_pkg::ST_SUB;
                end else begin
                    n_cnt = r_cnt + mllt_pkg::CNT_W'(1);
                end
            end
            mllt_pkg::ST_SUB: begin
                if (pass_end) begin
                    n_cnt   = '0;
                    n_state = mllt_pkg::ST_FIX;
                end else begin
                    n_cnt = r_cnt + mllt_pkg::CNT_W'(1);
                end
            end
            mllt_pkg::ST_FIX: begin
                if (pass_end) begin
                    n_cnt = '0;
                    if (r_left == mllt_pkg::EXP_W'(1)) begin
                        n_state = mllt_pkg::ST_CHECK;
                    end else begin
                        n_left  = r_left - mllt_pkg::EXP_W'(1);
                        n_col   = '0;
                        n_i     = '0;
                        n_state = mllt_pkg::ST_MUL;
                    end
                end else begin
                    n_cnt = r_cnt + mllt_pkg::CNT_W'(1);
                end
            end
            mllt_pkg::ST_CHECK: begin
                if (pass_end) begin
                    n_cnt   = '0;
                    n_state = mllt_pkg::ST_DONE;
                end else begin
                    n_cnt = r_cnt + mllt_pkg::CNT_W'(1);
                end
            end
            mllt_pkg::ST_DONE: begin
                n_state = mllt_pkg::ST_IDLE;
            end
            default: begin
                n_state = mllt_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and datapath commands
    always_comb begin
        o_cmd        = '0;
        o_cmd.op     = mllt_pkg::OP_NONE;
        o_cmd.idx_a  = r_cnt[mllt_pkg::LIMB_AW-1:0];
        o_cmd.col    = r_col;
        o_cmd.first  = (r_cnt == '0);
        o_cmd.last   = (r_cnt == r_n - mllt_pkg::CNT_W'(1));
        o_cmd.n      = r_n;
        o_cmd.rsh    = r_rsh;
        case (r_state)
            mllt_pkg::ST_INIT: begin
                if (!pass_end) o_cmd.op = mllt_pkg::OP_INIT;
            end
            mllt_pkg::ST_MUL: begin
                o_cmd.op    = mllt_pkg::OP_MUL;
                o_cmd.idx_a = r_i[mllt_pkg::LIMB_AW-1:0];
                o_cmd.idx_b = j_full[mllt_pkg::LIMB_AW-1:0];
                o_cmd.first = (r_i == i_lo);
                o_cmd.last  = mul_last;
                o_cmd.clear = (r_col == '0);
                o_cmd.zero  = dummy;
            end
            mllt_pkg::ST_FOLD_PRE: begin
                o_cmd.op     = mllt_pkg::OP_FOLD_PRE;
                o_cmd.sq_idx = (mllt_pkg::SQ_AW+1)'(r_w);
            end
            mllt_pkg::ST_FOLD: begin
                if (!pass_end) o_cmd.op = mllt_pkg::OP_FOLD;
                o_cmd.sq_idx = (mllt_pkg::SQ_AW+1)'(r_w) + (mllt_pkg::SQ_AW+1)'(r_cnt)
                               + (mllt_pkg::SQ_AW+1)'(1);
            end
            mllt_pkg::ST_SUB: begin
                if (!pass_end) o_cmd.op = mllt_pkg::OP_SUB;
            end
            mllt_pkg::ST_FIX: begin
                if (!pass_end) o_cmd.op = mllt_pkg::OP_FIX;
            end
            mllt_pkg::ST_CHECK: begin
                if (!pass_end) o_cmd.op = mllt_pkg::OP_CHECK;
            end
            default: begin
                o_cmd.op = mllt_pkg::OP_NONE;
            end
        endcase
        busy        = (r_state != mllt_pkg::ST_IDLE);
        o_done      = (r_state == mllt_pkg::ST_DONE);
        o_prime     = o_done && (r_special ? r_spec_prime : i_stat.is_zero);
        o_too_large = o_done && r_too_large;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= mllt_pkg::ST_IDLE;
            r_left       <= '0;
            r_cnt        <= '0;
            r_col        <= '0;
            r_i          <= '0;
            r_special    <= 1'b0;
            r_spec_prime <= 1'b0;
            r_too_large  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_left       <= n_left;
            r_cnt        <= n_cnt;
            r_col        <= n_col;
            r_i          <= n_i;
            r_special    <= n_special;
            r_spec_prime <= n_spec_prime;
            r_too_large  <= n_too_large;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n   <= n_n;
        r_w   <= n_w;
        r_rsh <= n_rsh;
    end

    `LLT_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    `LLT_ASSERT_NXT(a_done_idle, i_clk, i_rst_n, o_done, !busy)
    `LLT_ASSERT_IMP(a_dummy_last, i_clk, i_rst_n, o_cmd.zero, o_cmd.last && (o_cmd.op == mllt_pkg::OP_MUL))
    `LLT_ASSERT_IMP(a_large_special, i_clk, i_rst_n, o_too_large, r_special && !o_prime)

endmodule

/* rtl/mllt_dp.sv */
// ----------------------------------------------------------------------------
// mllt_dp
// limb memories, 64x64 multiply-accumulate pipeline and limb pass unit
// ----------------------------------------------------------------------------
module mllt_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mllt_pkg::t_dp_cmd    i_cmd,
    output mllt_pkg::t_dp_stat   o_stat
);

    typedef struct packed {
        logic                       first;
        logic                       last;
        logic                       clear;
        logic                       zero;
        logic [mllt_pkg::SQ_AW-1:0] col;
    } t_mul_tag;

    logic [mllt_pkg::LIMB_W-1:0]  r_res_mem [mllt_pkg::MAX_LIMBS];
    logic [mllt_pkg::LIMB_W-1:0]  r_sq_mem  [mllt_pkg::SQ_DEPTH];

    logic [mllt_pkg::LIMB_W-1:0]  r_res_a, r_res_b, r_sq_a, r_sq_b;

    mllt_pkg::t_dp_op             r_op1;
    logic [mllt_pkg::LIMB_AW-1:0] r_i1;
    logic                         r_bz1;
    t_mul_tag                     r_tag1, r_tag2, r_tag3;
    logic                         r_v2, r_v3;

    logic [mllt_pkg::LIMB_W-1:0]  r_pp00, r_pp01, r_pp10, r_pp11;
    logic [mllt_pkg::PROD_W-1:0]  r_prod, prod;
    logic [mllt_pkg::ACC_W-1:0]   r_acc, acc_base, acc_sum;

    logic [mllt_pkg::LIMB_W-1:0]  r_prev;
    logic                         r_carry, r_top, r_need_fix, r_z, r_m;

    logic [mllt_pkg::LIMB_W-1:0]  tmask, mask_i, nxt, hi, lo, sub_add, fix_val;
    logic [mllt_pkg::PROD_W-1:0]  shifted;
    logic [mllt_pkg::LIMB_W:0]    fold_sum, sub_sum;
    logic                         carry_in, z_in, m_in;

    logic                         res_we, sq_we;
    logic [mllt_pkg::LIMB_W-1:0]  res_wdata;

    // memories
    always_ff @(posedge i_clk) begin
        r_res_a <= r_res_mem[i_cmd.idx_a];
        r_res_b <= r_res_mem[i_cmd.idx_b];
        r_sq_a  <= r_sq_mem[mllt_pkg::SQ_AW'(i_cmd.idx_a)];
        r_sq_b  <= r_sq_mem[i_cmd.sq_idx[mllt_pkg::SQ_AW-1:0]];
        if (res_we) r_res_mem[r_i1] <= res_wdata;
        if (sq_we) r_sq_mem[r_tag3.col] <= acc_sum[mllt_pkg::LIMB_W-1:0];
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op1 <= mllt_pkg::OP_NONE;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
        end else begin
            r_op1 <= i_cmd.op;
            r_v2  <= (r_op1 == mllt_pkg::OP_MUL);
            r_v3  <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i1         <= i_cmd.idx_a;
        r_bz1        <= (i_cmd.sq_idx >= {i_cmd.n, 1'b0});
        r_tag1.first <= i_cmd.first;
        r_tag1.last  <= i_cmd.last;
        r_tag1.clear <= i_cmd.clear;
        r_tag1.zero  <= i_cmd.zero;
        r_tag1.col   <= i_cmd.col;
        r_tag2       <= r_tag1;
        r_tag3       <= r_tag2;
        r_pp00 <= mllt_pkg::LIMB_W'(r_res_a[mllt_pkg::HALF_W-1:0])
                  * mllt_pkg::LIMB_W'(r_res_b[mllt_pkg::HALF_W-1:0]);
        r_pp01 <= mllt_pkg::LIMB_W'(r_res_a[mllt_pkg::HALF_W-1:0])
                  * mllt_pkg::LIMB_W'(r_res_b[mllt_pkg::LIMB_W-1:mllt_pkg::HALF_W]);
        r_pp10 <= mllt_pkg::LIMB_W'(r_res_a[mllt_pkg::LIMB_W-1:mllt_pkg::HALF_W])
                  * mllt_pkg::LIMB_W'(r_res_b[mllt_pkg::HALF_W-1:0]);
        r_pp11 <= mllt_pkg::LIMB_W'(r_res_a[mllt_pkg::LIMB_W-1:mllt_pkg::HALF_W])
                  * mllt_pkg::LIMB_W'(r_res_b[mllt_pkg::LIMB_W-1:mllt_pkg::HALF_W]);
        r_prod <= r_tag2.zero ? '0 : prod;
        if (r_v3) r_acc <= acc_sum;
    end

    // product assembly and column accumulate
    always_comb begin
        prod = (mllt_pkg::PROD_W'(r_pp11) << mllt_pkg::LIMB_W)
             + (mllt_pkg::PROD_W'(r_pp01) << mllt_pkg::HALF_W)
             + (mllt_pkg::PROD_W'(r_pp10) << mllt_pkg::HALF_W)
             + mllt_pkg::PROD_W'(r_pp00);
        if (r_tag3.clear) begin
            acc_base = '0;
        end else if (r_tag3.first) begin
            acc_base = r_acc >> mllt_pkg::LIMB_W;
        end else begin
            acc_base = r_acc;
        end
        acc_sum = acc_base + mllt_pkg::ACC_W'(r_prod);
        sq_we   = r_v3 && r_tag3.last;
    end

    // limb passes
    always_comb begin
        tmask    = (i_cmd.rsh == '0) ? '1 :
                   ((mllt_pkg::LIMB_W'(1) << i_cmd.rsh) - mllt_pkg::LIMB_W'(1));
        mask_i   = r_tag1.last ? tmask : '1;
        carry_in = r_tag1.first ? 1'b0 : r_carry;
        nxt      = r_bz1 ? '0 : r_sq_b;
        shifted  = {nxt, r_prev} >> i_cmd.rsh;
        hi       = shifted[mllt_pkg::LIMB_W-1:0];
        lo       = r_sq_a & mask_i;
        fold_sum = (mllt_pkg::LIMB_W+1)'(lo) + (mllt_pkg::LIMB_W+1)'(hi)
                 + (mllt_pkg::LIMB_W+1)'(carry_in);
        sub_add  = (r_i1 == '0 && !r_top) ? ~mllt_pkg::LIMB_W'(1) : '1;
        sub_sum  = (mllt_pkg::LIMB_W+1)'(r_res_a) + (mllt_pkg::LIMB_W+1)'(sub_add)
                 + (mllt_pkg::LIMB_W+1)'(carry_in);
        fix_val  = ((r_need_fix && r_i1 == '0) ? r_res_a - mllt_pkg::LIMB_W'(1) : r_res_a)
                   & mask_i;
        z_in     = r_tag1.first ? 1'b1 : r_z;
        m_in     = r_tag1.first ? 1'b1 : r_m;
        res_we    = 1'b0;
        res_wdata = fix_val;
        case (r_op1)
            mllt_pkg::OP_INIT: begin
                res_we    = 1'b1;
                res_wdata = (r_i1 == '0) ? mllt_pkg::SEED : '0;
            end
            mllt_pkg::OP_FOLD: begin
                res_we    = 1'b1;
                res_wdata = fold_sum[mllt_pkg::LIMB_W-1:0] & mask_i;
            end
            mllt_pkg::OP_SUB: begin
                res_we    = 1'b1;
                res_wdata = sub_sum[mllt_pkg::LIMB_W-1:0];
            end
            mllt_pkg::OP_FIX: begin
                res_we    = 1'b1;
                res_wdata = fix_val;
            end
            default: begin
                res_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_op1)
            mllt_pkg::OP_FOLD_PRE: begin
                r_prev <= nxt;
            end
            mllt_pkg::OP_FOLD: begin
                r_prev  <= nxt;
                r_carry <= fold_sum[mllt_pkg::LIMB_W];
                if (r_tag1.last) begin
                    r_top <= (i_cmd.rsh == '0) ? fold_sum[mllt_pkg::LIMB_W]
                                               : fold_sum[i_cmd.rsh];
                end
            end
            mllt_pkg::OP_SUB: begin
                r_carry <= sub_sum[mllt_pkg::LIMB_W];
                if (r_tag1.last) r_need_fix <= !sub_sum[mllt_pkg::LIMB_W];
            end
            mllt_pkg::OP_CHECK: begin
                r_z <= z_in && (r_res_a == '0);
                r_m <= m_in && (r_res_a == mask_i);
            end
            default: begin
                r_carry <= r_carry;
            end
        endcase
    end

    assign o_stat.is_zero = r_z || r_m;

endmodule

/* rtl/mersenne_lucas_lehmer_test.sv */
// done strobe comes in the cycle after the accepting edge for exponents below three or above 1024;
// otherwise the run time is set by the one 64x64 multiply-accumulate per cycle,
// working on n = ceil(p/64) limbs
// one transaction at a time: start is taken only while busy is low
// reset (i_rst_n, synchronous, active low) clears the sequencer and pipeline valids;
// limb memories are not cleared, every limb is written before it is read; no output stall
// ----------------------------------------------------------------------------
// mersenne_lucas_lehmer_test
// lucas-lehmer primality test of 2^p-1 for p up to 1024
// ----------------------------------------------------------------------------
module mersenne_lucas_lehmer_test (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [mllt_pkg::EXP_W-1:0]  i_exponent,
    output logic                        o_done,
    output logic                        o_prime,
    output logic                        o_too_large
);

    mllt_pkg::t_dp_cmd  cmd;
    mllt_pkg::t_dp_stat stat;

    mllt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_exponent  (i_exponent),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_done      (o_done),
        .o_prime     (o_prime),
        .o_too_large (o_too_large)
    );

    mllt_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_stat  (stat)
    );

endmodule

/* tb/mersenne_lucas_lehmer_test_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mersenne_lucas_lehmer_test_tb
// exponents are driven through start/busy and every strobed verdict is compared
// with a big-vector lucas-lehmer computation done in the testbench itself
// ----------------------------------------------------------------------------
module mersenne_lucas_lehmer_test_tb;

    localparam int CYCLE_LIMIT = 10000000;

    typedef struct packed {
        logic prime;
        logic too_large;
    } t_verdict;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       start;
    logic                       busy;
    logic [mllt_pkg::EXP_W-1:0] i_exponent;
    logic                       o_done;
    logic                       o_prime;
    logic                       o_too_large;

    t_verdict verdict_q[$];
    int       fail_count;
    int       cycle_count;

    mersenne_lucas_lehmer_test DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_exponent  (i_exponent),
        .o_done      (o_done),
        .o_prime     (o_prime),
        .o_too_large (o_too_large)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic t_verdict expected_verdict(input int p);
        t_verdict        v;
        logic [2047:0]   modulus;
        logic [2047:0]   res;
        logic [2047:0]   sq;
        int              k;
        v = '0;
        if (p > mllt_pkg::LIMB_W * mllt_pkg::MAX_LIMBS) begin
            v.too_large = 1'b1;
        end else if (p == 2) begin
            v.prime = 1'b1;
        end else if (p > 2) begin
            modulus = (2048'(1) << p) - 2048'(1);
            res = 2048'(4);
            for (k = 0; k < p - 2; k++) begin
                sq = res * res;
                sq = (sq & modulus) + (sq >> p);
                sq = (sq & modulus) + (sq >> p);
                if (sq == modulus) sq = '0;
                if (sq >= 2048'(2)) res = sq - 2048'(2);
                else res = sq + modulus - 2048'(2);
            end
            v.prime = (res == '0);
        end
        return v;
    endfunction

    task automatic send_exponent(input int p);
        @(negedge i_clk);
        start      <= 1'b1;
        i_exponent <= mllt_pkg::EXP_W'(p);
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        verdict_q.push_back(expected_verdict(p));
        @(negedge i_clk);
        start <= 1'b0;
    endtask

    task automatic idle_gap();
        int n;
        if ($urandom_range(0, 9) < 3) return;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 4);
        repeat (n) @(negedge i_clk);
    endtask

    task automatic wait_drained();
        while (verdict_q.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_verdict exp_v;
        if (i_rst_n && o_done) begin
            if (verdict_q.size() == 0) begin
                $display("%0t unexpected transaction: actual prime=%b too_large=%b",
                         $time, o_prime, o_too_large);
                fail_count++;
            end else begin
                exp_v = verdict_q.pop_front();
                if (o_prime !== exp_v.prime) begin
                    $display("%0t prime mismatch: expected %b actual %b",
                             $time, exp_v.prime, o_prime);
                    fail_count++;
                end
                if (o_too_large !== exp_v.too_large) begin
                    $display("%0t too_large mismatch: expected %b actual %b",
                             $time, exp_v.too_large, o_too_large);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t timeout", $time);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic test_special_exponents();
        int list[$] = '{0, 1, 2, 3, 4, 1025, 1536, 2047, 1024 + 512 + 256 + 128};
        foreach (list[i]) send_exponent(list[i]);
    endtask

    task automatic test_small_primes();
        int list[$] = '{5, 7, 11, 13, 17, 19, 23, 31, 61, 89, 107};
        foreach (list[i]) begin
            send_exponent(list[i]);
            idle_gap();
        end
    endtask

    task automatic test_limb_boundaries();
        int list[$] = '{63, 64, 65, 127, 128, 129};
        foreach (list[i]) send_exponent(list[i]);
        wait_drained();
    endtask

    task automatic test_full_size();
        send_exponent(521);
        send_exponent(1024);
        wait_drained();
    endtask

    task automatic test_random_exponents();
        int p;
        int sel;
        for (int i = 0; i < 72; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 70) p = $urandom_range(0, 130);
            else if (sel < 82) p = $urandom_range(131, 300);
            else p = $urandom_range(1025, 2047);
            send_exponent(p);
            if (i == 36) wait_drained();
            else if (i < 62) idle_gap();
        end
    endtask

    initial begin
        fail_count  = 0;
        cycle_count = 0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_exponent  = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_special_exponents();
        test_small_primes();
        test_limb_boundaries();
        test_full_size();
        test_random_exponents();
        wait_drained();
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
